@@ rtl/core/uipz_pkg.sv @@
// ----------------------------------------------------------------------------
// uipz_pkg
// Shared types and constants for the USB IN packetizer with idle-timeout
// flush and zero-length packets.
// ----------------------------------------------------------------------------
package uipz_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 64;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned TIMEOUT_W        = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd10;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_ZLP
  } state_e;

endpackage

@@ rtl/core/uipz_store.sv @@
// ----------------------------------------------------------------------------
// uipz_store
// Packet byte store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module uipz_store #(
  parameter int unsigned PACKET_BYTES = uipz_pkg::PACKET_BYTES_DEF,
  parameter int unsigned ADDR_W       = $clog2(PACKET_BYTES)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [uipz_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [uipz_pkg::BYTE_W-1:0] rdata_o
);

  logic [uipz_pkg::BYTE_W-1:0] mem_q [PACKET_BYTES];
  logic [uipz_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/uipz_ctrl.sv @@
// ----------------------------------------------------------------------------
// uipz_ctrl
// Sequencer: fill count, zero-length mark and idle timer, and the emission
// burst that reads the store one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module uipz_ctrl #(
  parameter int unsigned PACKET_BYTES = uipz_pkg::PACKET_BYTES_DEF,
  parameter int unsigned ADDR_W       = $clog2(PACKET_BYTES),
  parameter int unsigned CNT_W        = $clog2(PACKET_BYTES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [uipz_pkg::TIMEOUT_W-1:0] timeout_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [uipz_pkg::KIND_W-1:0]    kind_i,
  input  logic [uipz_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [uipz_pkg::BYTE_W-1:0]    packet_byte_o,
  output logic                           last_o,
  output logic                           empty_packet_o,
  output logic                           we_o,
  output logic [ADDR_W-1:0]              waddr_o,
  output logic [uipz_pkg::BYTE_W-1:0]    wdata_o,
  output logic                           re_o,
  output logic [ADDR_W-1:0]              raddr_o,
  input  logic [uipz_pkg::BYTE_W-1:0]    rdata_i
);

  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(PACKET_BYTES);
  localparam logic [CNT_W-1:0] FULL_M1   = CNT_W'(PACKET_BYTES - 1);

  uipz_pkg::state_e             state_q, state_d;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic [CNT_W-1:0]             len_q, len_d;
  logic [ADDR_W-1:0]            idx_q, idx_d;
  logic                         zlp_q, zlp_d;
  logic [uipz_pkg::TIMEOUT_W-1:0] idle_q, idle_d;

  logic in_acc;
  logic out_acc;
  logic is_last;
  logic do_flush;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign is_last = (CNT_W'(idx_q) + CNT_W'(1)) == len_q;

  assign we_o    = in_acc && (kind_i == uipz_pkg::KIND_DATA);
  assign waddr_o = fill_q[ADDR_W-1:0];
  assign wdata_o = data_byte_i;

  // next state and datapath
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    len_d    = len_q;
    idx_d    = idx_q;
    zlp_d    = zlp_q;
    idle_d   = idle_q;
    re_o     = 1'b0;
    raddr_o  = '0;
    do_flush = 1'b0;
    case (state_q)
      uipz_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind_i)
            uipz_pkg::KIND_DATA: begin
              idle_d = '0;
              if (fill_q == FULL_M1) begin
                len_d   = FULL_CNT;
                fill_d  = '0;
                zlp_d   = 1'b1;
                idx_d   = '0;
                re_o    = 1'b1;
                state_d = uipz_pkg::ST_SEND;
              end else begin
                fill_d = fill_q + CNT_W'(1);
                zlp_d  = 1'b0;
              end
            end
            uipz_pkg::KIND_TICK: begin
              if (idle_q >= timeout_i) begin
                do_flush = 1'b1;
              end else begin
                idle_d = idle_q + uipz_pkg::TIMEOUT_W'(1);
              end
            end
            uipz_pkg::KIND_FLUSH: begin
              do_flush = 1'b1;
            end
            default: begin
            end
          endcase
          if (do_flush) begin
            if (fill_q != '0) begin
              len_d   = fill_q;
              fill_d  = '0;
              zlp_d   = 1'b0;
              idle_d  = '0;
              idx_d   = '0;
              re_o    = 1'b1;
              state_d = uipz_pkg::ST_SEND;
            end else if (zlp_q) begin
              zlp_d   = 1'b0;
              idle_d  = '0;
              state_d = uipz_pkg::ST_ZLP;
            end
          end
        end
      end
      uipz_pkg::ST_SEND: begin
        if (out_acc) begin
          if (is_last) begin
            state_d = uipz_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            re_o    = 1'b1;
            raddr_o = idx_q + ADDR_W'(1);
          end
        end
      end
      uipz_pkg::ST_ZLP: begin
        if (out_acc) begin
          state_d = uipz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = uipz_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    packet_byte_o  = '0;
    last_o         = 1'b0;
    empty_packet_o = 1'b0;
    case (state_q)
      uipz_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      uipz_pkg::ST_SEND: begin
        out_valid_o   = 1'b1;
        packet_byte_o = rdata_i;
        last_o        = is_last;
      end
      uipz_pkg::ST_ZLP: begin
        out_valid_o    = 1'b1;
        last_o         = 1'b1;
        empty_packet_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uipz_pkg::ST_IDLE;
      fill_q  <= '0;
      zlp_q   <= 1'b0;
      idle_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      zlp_q   <= zlp_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    idx_q <= idx_d;
  end

endmodule

@@ rtl/core/usb_in_packetizer_timeout_zlp.sv @@
// ----------------------------------------------------------------------------
// usb_in_packetizer_timeout_zlp
// USB bulk IN packetizer: collects bytes in a store, emits full packets,
// flushes partial packets on idle timeout or request, and on such a flush
// right after a full packet sends a zero-length packet.
// ----------------------------------------------------------------------------
// a transaction is taken when idle; the first result is valid the cycle
// after it; the taking cycle issues the first store read and one byte per
// cycle follows while the output is not stalled; a zero-length packet is a
// single item; output stalls hold the emission and input is stalled during
// emission; reset clears fill count, zero-length mark and idle timer and
// sets the timeout to ten ticks, the store is not cleared
// ----------------------------------------------------------------------------
module usb_in_packetizer_timeout_zlp #(
  parameter int unsigned PACKET_BYTES = uipz_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uipz_pkg::TIMEOUT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [uipz_pkg::KIND_W-1:0]    kind_i,
  input  logic [uipz_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [uipz_pkg::BYTE_W-1:0]    packet_byte_o,
  output logic                           last_o,
  output logic                           empty_packet_o
);

  localparam int unsigned ADDR_W = $clog2(PACKET_BYTES);
  localparam int unsigned CNT_W  = $clog2(PACKET_BYTES + 1);

  logic [uipz_pkg::TIMEOUT_W-1:0] timeout_q;
  logic                           we;
  logic [ADDR_W-1:0]              waddr;
  logic [uipz_pkg::BYTE_W-1:0]    wdata;
  logic                           re;
  logic [ADDR_W-1:0]              raddr;
  logic [uipz_pkg::BYTE_W-1:0]    rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= uipz_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  uipz_ctrl #(
    .PACKET_BYTES (PACKET_BYTES),
    .ADDR_W       (ADDR_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .timeout_i      (timeout_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packet_byte_o  (packet_byte_o),
    .last_o         (last_o),
    .empty_packet_o (empty_packet_o),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  uipz_store #(
    .PACKET_BYTES (PACKET_BYTES),
    .ADDR_W       (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // no write lands on the entry being read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("store write and read collide");

  // input is held off for the whole emission burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during emission");

  // a zero-length packet is a single closing item with a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_packet_o) |-> (last_o && (packet_byte_o == '0)))
    else $error("malformed zero-length packet");

  // the burst ends right after its final transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("output continues past packet end");

endmodule
